FILE: hw/rtl/zx0_pkg.sv
package zx0_pkg;

  localparam int unsigned WindowDepthDefault = 32768;

  localparam logic [1:0] ReqStart = 2'd0;
  localparam logic [1:0] ReqByte  = 2'd1;
  localparam logic [1:0] ReqTick  = 2'd2;

  localparam logic [1:0] WantByte = 2'd0;
  localparam logic [1:0] WantTick = 2'd1;
  localparam logic [1:0] WantStop = 2'd2;

  localparam logic [2:0] StRun   = 3'd0;
  localparam logic [2:0] StDone  = 3'd1;
  localparam logic [2:0] StTrunc = 3'd2;
  localparam logic [2:0] StBad   = 3'd3;
  localparam logic [2:0] StFull  = 3'd4;
  localparam logic [2:0] StIdle  = 3'd5;

  localparam logic [2:0] FsLenCont = 3'd0;
  localparam logic [2:0] FsLenData = 3'd1;
  localparam logic [2:0] FsOfsCont = 3'd2;
  localparam logic [2:0] FsOfsData = 3'd3;
  localparam logic [2:0] FsOfsLow  = 3'd4;
  localparam logic [2:0] FsLiteral = 3'd5;
  localparam logic [2:0] FsCopy    = 3'd6;
  localparam logic [2:0] FsSelect  = 3'd7;

  localparam logic [0:0] CfgPackedLength = 1'd0;
  localparam logic [0:0] CfgCapacity     = 1'd1;

endpackage

FILE: hw/rtl/zx0_ram.sv
module zx0_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/zx0_stream_decompressor.sv
// Channel  Direction  Fields (tdata low bit up)
// s_axis   in         tdata: data_byte[7:0]; tuser: req_type[1:0]
// m_axis   out        tdata: out_valid, out_byte, accepted, wants, status, total_bytes, pad
// cfg      in         cfg_we_i, cfg_index_i, cfg_wdata_i
// A rejected transaction is accepted and its result then goes straight to the output register.
// An accepted one steps through the shared bit decoder, one control bit per cycle (at most eight
// bits per item), after a history read on a copy tick, before any wait on m_axis_tready.
// The result sits in an output register; the next item is taken once it is delivered.
// Reset clears all control state; the history memory is not cleared.
module zx0_stream_decompressor
  import zx0_pkg::*;
#(
  parameter int unsigned WindowDepth = WindowDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_valid, out_byte, accepted, wants, status,
                                     // total_bytes
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned Aw = $clog2(WindowDepth);

  typedef enum logic [1:0] {Idle, Read, Step, Out} seq_e;
  seq_e seq_q;

  logic [15:0] plen_q, cap_q;
  logic [1:0]  phase_q;
  logic [2:0]  fs_q, rst_q;
  logic [7:0]  ctrl_q, mask_q;
  logic        bp_q, bb_q;
  logic [15:0] gamma_q, left_q, used_q, dist_q, cnt_q;
  logic        ov_q, acc_q;
  logic [7:0]  ob_q;

  logic [Aw-1:0] raddr;
  logic [7:0]    rdata;
  logic [15:0]   src;

  assign src   = used_q - dist_q;
  assign raddr = src[Aw-1:0];

  logic [1:0] wants;
  always_comb begin
    if (rst_q != StRun) wants = WantStop;
    else if (fs_q == FsCopy) wants = WantTick;
    else wants = WantByte;
  end

  assign s_axis_tready = (seq_q == Idle);
  assign m_axis_tvalid = (seq_q == Out);
  assign m_axis_tdata  = {1'b0, used_q, (rst_q == StIdle) ? StRun : rst_q, wants, acc_q,
                          ob_q, ov_q};

  // bit decoder: one control bit per cycle
  logic        have_bit, bitv, stop;
  logic [16:0] n;
  always_comb begin
    have_bit = 1'b0;
    bitv     = 1'b0;
    stop     = 1'b0;
    if (rst_q != StRun || fs_q == FsLiteral || fs_q == FsCopy || fs_q == FsOfsLow) begin
      stop = 1'b1;
    end else if (bp_q) begin
      have_bit = 1'b1;
      bitv     = bb_q;
    end else if (mask_q == 8'd0) begin
      stop = 1'b1;
    end else begin
      have_bit = 1'b1;
      bitv     = (ctrl_q & mask_q) != 8'd0;
    end
    n = {1'b0, gamma_q} + {16'd0, phase_q == 2'd2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= Idle; plen_q <= 16'd1; cap_q <= 16'hFFFF;
      phase_q <= 2'd0; fs_q <= FsLenCont; rst_q <= StIdle;
      ctrl_q <= '0; mask_q <= '0; bp_q <= 1'b0; bb_q <= 1'b0;
      gamma_q <= 16'd1; left_q <= '0; used_q <= '0; dist_q <= 16'd1; cnt_q <= '0;
      ov_q <= 1'b0; acc_q <= 1'b0; ob_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgPackedLength) plen_q <= cfg_wdata_i;
        else cap_q <= cfg_wdata_i;
      end
      case (seq_q)
        Idle: if (s_axis_tvalid) begin
          ov_q <= 1'b0; ob_q <= '0; acc_q <= 1'b0;
          seq_q <= Step;
          if (s_axis_tuser == ReqStart) begin
            acc_q <= 1'b1; phase_q <= 2'd0; fs_q <= FsLenCont; ctrl_q <= '0;
            mask_q <= '0; bp_q <= 1'b0; bb_q <= 1'b0; gamma_q <= 16'd1;
            left_q <= plen_q; used_q <= '0; dist_q <= 16'd1; cnt_q <= '0;
            rst_q <= StRun;
          end else if (s_axis_tuser == ReqByte && wants == WantByte) begin
            acc_q <= 1'b1;
            left_q <= left_q - 16'd1;
            if (fs_q == FsLiteral) begin
              ov_q <= 1'b1; ob_q <= s_axis_tdata;
              used_q <= used_q + 16'd1; cnt_q <= cnt_q - 16'd1;
              if (cnt_q == 16'd1) fs_q <= FsSelect;
            end else if (fs_q == FsOfsLow) begin
              dist_q <= {gamma_q[8:0], 7'd0} - {9'd0, s_axis_tdata[7:1]};
              bp_q <= 1'b1; bb_q <= s_axis_tdata[0];
              gamma_q <= 16'd1; fs_q <= FsLenCont;
            end else begin
              ctrl_q <= s_axis_tdata; mask_q <= 8'd128;
            end
          end else if (s_axis_tuser == ReqTick && wants == WantTick) begin
            acc_q <= 1'b1;
            seq_q <= Read;
          end else begin
            seq_q <= Out;
          end
        end
        Read: begin
          ov_q <= 1'b1; ob_q <= rdata;
          used_q <= used_q + 16'd1; cnt_q <= cnt_q - 16'd1;
          if (cnt_q == 16'd1) fs_q <= FsSelect;
          seq_q <= Step;
        end
        Step: begin
          if (stop) begin
            if (rst_q == StRun && fs_q != FsLiteral && fs_q != FsCopy && left_q == 16'd0)
              rst_q <= StTrunc;
            seq_q <= Out;
          end else if (have_bit) begin
            if (bp_q) bp_q <= 1'b0;
            else mask_q <= mask_q >> 1;
            case (fs_q)
              FsLenCont: begin
                if (bitv) begin
                  if (phase_q == 2'd2 && gamma_q == 16'hFFFF) rst_q <= StBad;
                  else if (n + {1'b0, used_q} > {1'b0, cap_q}) rst_q <= StFull;
                  else if (phase_q == 2'd0) begin
                    if (n > {1'b0, left_q}) rst_q <= StTrunc;
                    else begin fs_q <= FsLiteral; cnt_q <= n[15:0]; end
                  end else begin
                    if (dist_q > used_q) rst_q <= StBad;
                    else begin fs_q <= FsCopy; cnt_q <= n[15:0]; end
                  end
                end else if (gamma_q[15]) rst_q <= StBad;
                else fs_q <= FsLenData;
              end
              FsLenData: begin
                gamma_q <= {gamma_q[14:0], bitv}; fs_q <= FsLenCont;
              end
              FsOfsCont: begin
                if (bitv) begin
                  if (gamma_q == 16'd256) rst_q <= (left_q != 16'd0) ? StBad : StDone;
                  else if (gamma_q > 16'd255) rst_q <= StBad;
                  else fs_q <= FsOfsLow;
                end else if (gamma_q[15]) rst_q <= StBad;
                else fs_q <= FsOfsData;
              end
              FsOfsData: begin
                gamma_q <= {gamma_q[14:0], ~bitv}; fs_q <= FsOfsCont;
              end
              default: begin
                gamma_q <= 16'd1;
                if (bitv) begin phase_q <= 2'd2; fs_q <= FsOfsCont; end
                else begin
                  phase_q <= (phase_q == 2'd0) ? 2'd1 : 2'd0; fs_q <= FsLenCont;
                end
              end
            endcase
          end
        end
        Out: if (m_axis_tready) seq_q <= Idle;
        default: seq_q <= Idle;
      endcase
    end
  end

  // history write: store each emitted byte, registered from Idle (literal) or Read (copy)
  logic          hw_en_q;
  logic [Aw-1:0] hw_addr_q;
  logic [7:0]    hw_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_en_q <= 1'b0; hw_addr_q <= '0; hw_data_q <= '0;
    end else begin
      hw_en_q <= 1'b0;
      if (seq_q == Idle && s_axis_tvalid && s_axis_tuser == ReqByte && wants == WantByte
          && fs_q == FsLiteral) begin
        hw_en_q <= 1'b1; hw_addr_q <= used_q[Aw-1:0]; hw_data_q <= s_axis_tdata;
      end else if (seq_q == Read) begin
        hw_en_q <= 1'b1; hw_addr_q <= used_q[Aw-1:0]; hw_data_q <= rdata;
      end
    end
  end

  zx0_ram #(.Width(8), .Depth(WindowDepth)) u_hist (
    .clk_i, .we_i(hw_en_q), .waddr_i(hw_addr_q), .wdata_i(hw_data_q),
    .raddr_i(raddr), .rdata_o(rdata)
  );

endmodule
